[design/smbs_pkg.sv]
// shared types and constants of the spi master byte shifter
package smbs_pkg;

    // command codes carried by the mode field, also the running operation
    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_CS    = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // configuration register indexes
    localparam logic CFG_SPI_MODE    = 1'b0;
    localparam logic CFG_HALF_PERIOD = 1'b1;

    localparam int CFG_INDEX_WIDTH = 1;
    localparam int SPI_MODE_WIDTH  = 2;

endpackage

[design/spi_master_byte_shifter_core.sv]
// spi master byte shifter, one tick per input transaction, four cpol/cpha modes
//
// input channel: each transaction is one divider tick. it carries the miso
// sample and, while no transfer runs, a command: set chip select, write a word
// msb first or read a word msb first. commands that arrive while busy are
// dropped together with their cs_active and tx_byte.
// output channel: exactly one transaction per input transaction, holding the
// sclk, mosi and cs_n levels after that tick, the busy flag, the last word read
// and a pulse on the tick a read finishes.
// configuration: i_cfg_we writes register i_cfg_index (0 spi mode, 1 half
// period in ticks, 0 taken as 1); write only while the block is idle.
// results: the result of an accepted tick is registered in the output
// register, or in the skid register while the output is held. throughput:
// one tick per clock while o_in_stall is low, set by the combinational state
// update between the input handshake and the result register.
// stalls: a result register plus a one-entry skid register sit on the output
// side, so a tick is still taken while one result waits; o_in_stall rises
// only when both hold a result.
// reset: synchronous, active low. cs_n goes high, sclk/mosi low, no transfer
// runs, spi mode 0 and half period 1; both output entries are emptied.
module spi_master_byte_shifter_core #(
    parameter int DATA_BITS     = 8,
    parameter int DIVIDER_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [smbs_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [DIVIDER_WIDTH-1:0]               i_cfg_data,
    // tick input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_mode,
    input  logic                                   i_cs_active,
    input  logic [DATA_BITS-1:0]                   i_tx_byte,
    input  logic                                   i_miso,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_sclk,
    output logic                                   o_mosi,
    output logic                                   o_cs_n,
    output logic                                   o_busy_res,
    output logic [DATA_BITS-1:0]                   o_rx_byte,
    output logic                                   o_rx_done
);

    localparam int BITS_WIDTH = $clog2(DATA_BITS + 1);

    typedef struct packed {
        logic                 sclk;
        logic                 mosi;
        logic                 cs_n;
        logic                 busy;
        logic [DATA_BITS-1:0] rx_byte;
        logic                 rx_done;
    } t_result;

    // configuration registers
    logic [smbs_pkg::SPI_MODE_WIDTH-1:0] r_spi_mode;
    logic [DIVIDER_WIDTH-1:0]            r_half_period;

    // shifter state
    logic [DATA_BITS-1:0]     r_tx_shift, n_tx_shift;
    logic [DATA_BITS-1:0]     r_rx_shift, n_rx_shift;
    logic [DATA_BITS-1:0]     r_last_rx, n_last_rx;
    logic [BITS_WIDTH-1:0]    r_bits_left, n_bits_left;
    logic                     r_second_half, n_second_half;
    logic [DIVIDER_WIDTH-1:0] r_tick_count, n_tick_count;
    smbs_pkg::t_op            r_op, n_op;
    logic                     r_clock, n_clock;
    logic                     r_data, n_data;
    logic                     r_select, n_select;
    logic                     n_done;

    // output register and skid entry
    t_result r_out, r_skid, n_res;
    logic    r_out_valid, r_skid_valid;

    logic                     in_accept;
    logic                     out_free;
    logic                     cpol, cpha;
    logic [DIVIDER_WIDTH-1:0] half_eff;
    logic [DIVIDER_WIDTH-1:0] tick_inc;
    logic [BITS_WIDTH-1:0]    bits_dec;
    smbs_pkg::t_op            cmd;

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign cpol     = r_spi_mode[1];
    assign cpha     = r_spi_mode[0];
    assign half_eff = (r_half_period == '0) ? DIVIDER_WIDTH'(1) : r_half_period;
    assign tick_inc = r_tick_count + DIVIDER_WIDTH'(1);
    assign bits_dec = (r_bits_left != '0) ? (r_bits_left - BITS_WIDTH'(1)) : '0;
    assign cmd      = smbs_pkg::t_op'(i_mode);

    // next state of one tick
    always_comb begin
        n_tx_shift    = r_tx_shift;
        n_rx_shift    = r_rx_shift;
        n_last_rx     = r_last_rx;
        n_bits_left   = r_bits_left;
        n_second_half = r_second_half;
        n_tick_count  = r_tick_count;
        n_op          = r_op;
        n_clock       = r_clock;
        n_data        = r_data;
        n_select      = r_select;
        n_done        = 1'b0;

        if (r_op == smbs_pkg::OP_IDLE) begin
            // clock follows polarity at once while idle
            n_clock = cpol;
            case (cmd)
                smbs_pkg::OP_CS: begin
                    n_select = !i_cs_active;
                end
                smbs_pkg::OP_WRITE, smbs_pkg::OP_READ: begin
                    n_op          = cmd;
                    n_bits_left   = BITS_WIDTH'(DATA_BITS);
                    n_second_half = 1'b0;
                    n_tick_count  = '0;
                    if (cmd == smbs_pkg::OP_WRITE) begin
                        n_tx_shift = i_tx_byte;
                        if (!cpha) begin
                            n_data = i_tx_byte[DATA_BITS-1];
                        end
                    end else begin
                        n_rx_shift = '0;
                    end
                end
                default: ;
            endcase
        end else begin
            n_tick_count = tick_inc;
            if (tick_inc >= half_eff) begin
                n_tick_count = '0;
                if (!r_second_half) begin
                    // leading edge
                    n_clock = !cpol;
                    if (!cpha) begin
                        if (r_op == smbs_pkg::OP_READ) begin
                            n_rx_shift = {r_rx_shift[DATA_BITS-2:0], i_miso};
                        end
                    end else if (r_op == smbs_pkg::OP_WRITE) begin
                        n_data = r_tx_shift[DATA_BITS-1];
                    end
                    n_second_half = 1'b1;
                end else begin
                    // trailing edge
                    n_clock = cpol;
                    if (cpha && r_op == smbs_pkg::OP_READ) begin
                        n_rx_shift = {r_rx_shift[DATA_BITS-2:0], i_miso};
                    end
                    n_tx_shift    = {r_tx_shift[DATA_BITS-2:0], 1'b0};
                    n_second_half = 1'b0;
                    n_bits_left   = bits_dec;
                    if (bits_dec == '0) begin
                        if (r_op == smbs_pkg::OP_READ) begin
                            n_last_rx = n_rx_shift;
                            n_done    = 1'b1;
                        end
                        n_op = smbs_pkg::OP_IDLE;
                    end else if (!cpha && r_op == smbs_pkg::OP_WRITE) begin
                        n_data = r_tx_shift[DATA_BITS-2];
                    end
                end
            end
        end

        n_res.sclk    = n_clock;
        n_res.mosi    = n_data;
        n_res.cs_n    = n_select;
        n_res.busy    = (n_op != smbs_pkg::OP_IDLE);
        n_res.rx_byte = n_last_rx;
        n_res.rx_done = n_done;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spi_mode    <= '0;
            r_half_period <= DIVIDER_WIDTH'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                smbs_pkg::CFG_SPI_MODE: begin
                    r_spi_mode <= i_cfg_data[smbs_pkg::SPI_MODE_WIDTH-1:0];
                end
                smbs_pkg::CFG_HALF_PERIOD: begin
                    r_half_period <= i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    // shifter state advances once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_shift    <= '0;
            r_rx_shift    <= '0;
            r_last_rx     <= '0;
            r_bits_left   <= '0;
            r_second_half <= 1'b0;
            r_tick_count  <= '0;
            r_op          <= smbs_pkg::OP_IDLE;
            r_clock       <= 1'b0;
            r_data        <= 1'b0;
            r_select      <= 1'b1;
        end else if (in_accept) begin
            r_tx_shift    <= n_tx_shift;
            r_rx_shift    <= n_rx_shift;
            r_last_rx     <= n_last_rx;
            r_bits_left   <= n_bits_left;
            r_second_half <= n_second_half;
            r_tick_count  <= n_tick_count;
            r_op          <= n_op;
            r_clock       <= n_clock;
            r_data        <= n_data;
            r_select      <= n_select;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else if (in_accept) begin
                r_out       <= n_res;
                r_out_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (in_accept) begin
            r_skid       <= n_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sclk      = r_out.sclk;
    assign o_mosi      = r_out.mosi;
    assign o_cs_n      = r_out.cs_n;
    assign o_busy_res  = r_out.busy;
    assign o_rx_byte   = r_out.rx_byte;
    assign o_rx_done   = r_out.rx_done;

    // skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // a transfer runs exactly while bits remain
    a_bits_match_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op != smbs_pkg::OP_IDLE) == (r_bits_left != '0))
        else $error("bit counter disagrees with running operation");

    // idle always leaves the clock in its first half
    a_idle_first_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op == smbs_pkg::OP_IDLE) |-> !r_second_half)
        else $error("idle with half period phase still set");

    // a finished read reports not busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.rx_done) |-> !r_out.busy)
        else $error("read completion reported while busy");

endmodule

[sim/spi_master_byte_shifter_core_test.sv]
// self-checking testbench of the spi master byte shifter core
`timescale 1ns / 1ps
module spi_master_byte_shifter_core_test;

    localparam int WORD_BITS     = 8;
    localparam int DIV_BITS      = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_TICKS   = 100;
    localparam int RANDOM_PHASES = 3;
    // half periods above this run a single transfer only; the maximum runs none
    localparam logic [DIV_BITS-1:0] SLOW_HALF = 16'd16;
    localparam logic [DIV_BITS-1:0] MAX_HALF  = 16'hFFFF;

    // line levels after one tick, in the order of the result ports
    typedef struct packed {
        logic                 sclk;
        logic                 mosi;
        logic                 cs_n;
        logic                 busy;
        logic [WORD_BITS-1:0] rx_byte;
        logic                 rx_done;
    } t_levels;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        smbs_pkg::t_op        cmd;
        logic                 cs_active;
        logic [WORD_BITS-1:0] tx_byte;
        logic                 miso;
        logic                 typed;
        t_levels              levels;
    } t_tick_row;

    // reset settings: mode 0, half period 1
    // a write of 0xff, commands thrown at it while it runs, then a read that
    // the first settling pass finishes
    localparam t_tick_row DIRECTED_TICKS [23] = '{
        '{smbs_pkg::OP_IDLE,  1'b0, 8'h00, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{smbs_pkg::OP_CS,    1'b1, 8'h00, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{smbs_pkg::OP_WRITE, 1'b0, 8'hFF, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
        '{smbs_pkg::OP_IDLE,  1'b0, 8'h00, 1'b1, 1'b0, '0},
        '{smbs_pkg::OP_READ,  1'b0, 8'h00, 1'b1, 1'b0, '0},
        '{smbs_pkg::OP_CS,    1'b0, 8'hFF, 1'b0, 1'b0, '0},
        '{smbs_pkg::OP_WRITE, 1'b1, 8'h00, 1'b1, 1'b0, '0},
        '{smbs_pkg::OP_IDLE,  1'b1, 8'h55, 1'b0, 1'b0, '0},
        '{smbs_pkg::OP_IDLE,  1'b0, 8'hAA, 1'b1, 1'b0, '0},
        '{smbs_pkg::OP_IDLE,  1'b1, 8'h55, 1'b0, 1'b0, '0},
        '{smbs_pkg::OP_IDLE,  1'b0, 8'hAA, 1'b1, 1'b0, '0},
        '{smbs_pkg::OP_CS,    1'b0, 8'h55, 1'b0, 1'b0, '0},
        '{smbs_pkg::OP_IDLE,  1'b0, 8'hAA, 1'b1, 1'b0, '0},
        '{smbs_pkg::OP_IDLE,  1'b1, 8'h55, 1'b0, 1'b0, '0},
        '{smbs_pkg::OP_READ,  1'b0, 8'hAA, 1'b1, 1'b0, '0},
        '{smbs_pkg::OP_IDLE,  1'b1, 8'h55, 1'b0, 1'b0, '0},
        '{smbs_pkg::OP_IDLE,  1'b0, 8'hAA, 1'b1, 1'b0, '0},
        '{smbs_pkg::OP_IDLE,  1'b1, 8'h55, 1'b0, 1'b0, '0},
        '{smbs_pkg::OP_IDLE,  1'b0, 8'hAA, 1'b1, 1'b0, '0},
        '{smbs_pkg::OP_READ,  1'b0, 8'h00, 1'b1, 1'b0, '0},
        '{smbs_pkg::OP_IDLE,  1'b0, 8'h00, 1'b0, 1'b0, '0},
        '{smbs_pkg::OP_IDLE,  1'b0, 8'h00, 1'b1, 1'b0, '0},
        '{smbs_pkg::OP_CS,    1'b0, 8'h00, 1'b1, 1'b0, '0}
    };

    // fixed settings walked after the directed part, random ones follow
    localparam logic [1:0]          PHASE_MODE [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0,
                                                        2'd1, 2'd2, 2'd3, 2'd2, 2'd1};
    localparam logic [DIV_BITS-1:0] PHASE_HALF [10] = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd0,
                                                        16'd2, 16'd3, 16'd4, 16'd20,
                                                        16'hFFFF};

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_cfg_we;
    logic [smbs_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [DIV_BITS-1:0]                  i_cfg_data;
    logic                                 i_in_valid;
    logic                                 o_in_stall;
    logic [1:0]                           i_mode;
    logic                                 i_cs_active;
    logic [WORD_BITS-1:0]                 i_tx_byte;
    logic                                 i_miso;
    logic                                 o_out_valid;
    logic                                 i_out_stall;
    logic                                 o_sclk;
    logic                                 o_mosi;
    logic                                 o_cs_n;
    logic                                 o_busy_res;
    logic [WORD_BITS-1:0]                 o_rx_byte;
    logic                                 o_rx_done;

    // predicted line state and register copies
    logic [smbs_pkg::SPI_MODE_WIDTH-1:0]  cfg_spi_mode;
    logic [DIV_BITS-1:0]                  cfg_half_period;
    smbs_pkg::t_op                        op_running;
    logic [WORD_BITS-1:0]                 tx_word;
    logic [WORD_BITS-1:0]                 rx_word;
    logic [3:0]                           bits_to_go;
    logic                                 in_second_half;
    logic [DIV_BITS-1:0]                  half_count;
    logic                                 sclk_level;
    logic                                 mosi_level;
    logic                                 cs_n_level;
    logic [WORD_BITS-1:0]                 rx_held;

    t_levels     expected_levels [$];
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned miso_style;
    int unsigned ticks_sent;
    int unsigned writes_started;
    int unsigned reads_started;
    int unsigned reads_done;
    int unsigned settings_used;

    spi_master_byte_shifter_core dut (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // line levels after one tick; advances the predicted state
    function automatic t_levels next_line_levels(input smbs_pkg::t_op cmd,
                                                 input logic cs_active,
                                                 input logic [WORD_BITS-1:0] tx_byte,
                                                 input logic miso_bit);
        logic                cpol;
        logic                cpha;
        logic [DIV_BITS-1:0] limit;
        logic                done;
        t_levels             lv;
        cpol  = cfg_spi_mode[1];
        cpha  = cfg_spi_mode[0];
        // a zero half period behaves like one tick
        limit = (cfg_half_period == '0) ? DIV_BITS'(1) : cfg_half_period;
        done  = 1'b0;
        if (op_running == smbs_pkg::OP_IDLE) begin
            // idle clock follows the polarity right away
            sclk_level = cpol;
            if (cmd == smbs_pkg::OP_CS) begin
                cs_n_level = ~cs_active;
            end else if (cmd == smbs_pkg::OP_WRITE || cmd == smbs_pkg::OP_READ) begin
                op_running     = cmd;
                bits_to_go     = 4'(WORD_BITS);
                in_second_half = 1'b0;
                half_count     = '0;
                if (cmd == smbs_pkg::OP_WRITE) begin
                    tx_word = tx_byte;
                    // phase 0 puts the first bit out before the first edge
                    if (!cpha) mosi_level = tx_byte[WORD_BITS-1];
                end else begin
                    rx_word = '0;
                end
            end
        end else begin
            // commands during a transfer are dropped
            half_count = half_count + 1'b1;
            if (half_count >= limit) begin
                half_count = '0;
                if (!in_second_half) begin
                    sclk_level = ~cpol;
                    if (!cpha) begin
                        if (op_running == smbs_pkg::OP_READ) begin
                            rx_word = {rx_word[WORD_BITS-2:0], miso_bit};
                        end
                    end else if (op_running == smbs_pkg::OP_WRITE) begin
                        mosi_level = tx_word[WORD_BITS-1];
                    end
                    in_second_half = 1'b1;
                end else begin
                    sclk_level = cpol;
                    if (cpha && op_running == smbs_pkg::OP_READ) begin
                        rx_word = {rx_word[WORD_BITS-2:0], miso_bit};
                    end
                    tx_word        = tx_word << 1;
                    in_second_half = 1'b0;
                    if (bits_to_go != 0) bits_to_go = bits_to_go - 1'b1;
                    if (bits_to_go == 0) begin
                        if (op_running == smbs_pkg::OP_READ) begin
                            rx_held = rx_word;
                            done    = 1'b1;
                        end
                        op_running = smbs_pkg::OP_IDLE;
                    end else if (!cpha && op_running == smbs_pkg::OP_WRITE) begin
                        mosi_level = tx_word[WORD_BITS-1];
                    end
                end
            end
        end
        lv.sclk    = sclk_level;
        lv.mosi    = mosi_level;
        lv.cs_n    = cs_n_level;
        lv.busy    = (op_running != smbs_pkg::OP_IDLE);
        lv.rx_byte = rx_held;
        lv.rx_done = done;
        return lv;
    endfunction

    // register write at a falling edge, taken at the next rising edge
    task automatic write_register(input logic [smbs_pkg::CFG_INDEX_WIDTH-1:0] index,
                                  input logic [DIV_BITS-1:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        if (index == smbs_pkg::CFG_SPI_MODE) cfg_spi_mode = value[smbs_pkg::SPI_MODE_WIDTH-1:0];
        else cfg_half_period = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // one tick transaction; called at a falling edge and returns at one.
    // valid stays high afterwards so back-to-back transactions need no gap
    task automatic send_tick(input smbs_pkg::t_op cmd, input logic cs_active,
                             input logic [WORD_BITS-1:0] tx_byte, input logic miso_bit,
                             input logic typed, input t_levels typed_levels);
        t_levels predicted;
        if (burst_left == 0) begin
            // gap between bursts, then mostly short bursts and now and then a long one
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        i_mode      = cmd;
        i_cs_active = cs_active;
        i_tx_byte   = tx_byte;
        i_miso      = miso_bit;
        i_in_valid  = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (op_running == smbs_pkg::OP_IDLE && cmd == smbs_pkg::OP_WRITE) writes_started++;
        if (op_running == smbs_pkg::OP_IDLE && cmd == smbs_pkg::OP_READ) reads_started++;
        predicted = next_line_levels(cmd, cs_active, tx_byte, miso_bit);
        expected_levels.push_back(typed ? typed_levels : predicted);
        ticks_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // miso level for the running read: stuck low, stuck high or random
    function automatic logic miso_for_tick();
        case (miso_style)
            0: return 1'b0;
            1: return 1'b1;
            default: return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // random byte leaning toward the corner patterns
    function automatic logic [WORD_BITS-1:0] random_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h01;
            default: return 8'($urandom);
        endcase
    endfunction

    // random tick: mostly well-formed commands while idle, some noise while busy
    task automatic random_tick(input logic transfers_ok);
        smbs_pkg::t_op cmd;
        int unsigned   pick;
        pick = $urandom_range(0, 99);
        if (op_running != smbs_pkg::OP_IDLE) begin
            cmd = (pick < 10) ? smbs_pkg::t_op'($urandom_range(0, 3)) : smbs_pkg::OP_IDLE;
        end else if (!transfers_ok) begin
            cmd = (pick < 50) ? smbs_pkg::OP_CS : smbs_pkg::OP_IDLE;
        end else if (pick < 40) begin
            cmd = smbs_pkg::OP_WRITE;
        end else if (pick < 80) begin
            cmd = smbs_pkg::OP_READ;
        end else if (pick < 92) begin
            cmd = smbs_pkg::OP_CS;
        end else begin
            cmd = smbs_pkg::OP_IDLE;
        end
        if (op_running == smbs_pkg::OP_IDLE && cmd == smbs_pkg::OP_READ) begin
            miso_style = $urandom_range(0, 3);
        end
        send_tick(cmd, 1'($urandom_range(0, 1)), random_byte(), miso_for_tick(), 1'b0, '0);
    endtask

    // run the transfer out, then hold the sender until every result is back
    task automatic settle_idle();
        while (op_running != smbs_pkg::OP_IDLE) begin
            send_tick(smbs_pkg::OP_IDLE, 1'($urandom_range(0, 1)), random_byte(),
                      miso_for_tick(), 1'b0, '0);
        end
        i_in_valid = 1'b0;
        while (expected_levels.size() != 0) @(negedge i_clk);
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    // receiver stall: a random style held for a random stretch, including none at all
    initial begin
        int unsigned          style;
        int unsigned          left;
        logic [7:0]           pattern;
        style       = 0;
        left        = 0;
        pattern     = '0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                style   = $urandom_range(0, 3);
                pattern = 8'($urandom);
                left    = $urandom_range(20, 80);
            end
            left--;
            case (style)
                0: i_out_stall = 1'b0;
                1: i_out_stall = ($urandom_range(0, 3) == 0);
                2: begin
                    i_out_stall = pattern[0];
                    pattern     = {pattern[0], pattern[7:1]};
                end
                default: i_out_stall = ($urandom_range(0, 9) < 6);
            endcase
        end
    end

    // result transactions against the oldest expectation
    always @(posedge i_clk) begin
        t_levels want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_levels.size() == 0) begin
                $error("result transaction with no expectation waiting");
                mismatches++;
            end else begin
                want = expected_levels.pop_front();
                compare_field("sclk", 32'(want.sclk), 32'(o_sclk));
                compare_field("mosi", 32'(want.mosi), 32'(o_mosi));
                compare_field("cs_n", 32'(want.cs_n), 32'(o_cs_n));
                compare_field("busy_res", 32'(want.busy), 32'(o_busy_res));
                compare_field("rx_byte", 32'(want.rx_byte), 32'(o_rx_byte));
                compare_field("rx_done", 32'(want.rx_done), 32'(o_rx_done));
                if (o_rx_done) reads_done++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [1:0]          mode_now;
        logic [DIV_BITS-1:0] half_now;
        // known levels on every input from time zero
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = smbs_pkg::CFG_SPI_MODE;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_mode      = smbs_pkg::OP_IDLE;
        i_cs_active = 1'b0;
        i_tx_byte   = '0;
        i_miso      = 1'b0;
        // predictor at its reset state
        cfg_spi_mode    = '0;
        cfg_half_period = DIV_BITS'(1);
        op_running      = smbs_pkg::OP_IDLE;
        tx_word         = '0;
        rx_word         = '0;
        bits_to_go      = '0;
        in_second_half  = 1'b0;
        half_count      = '0;
        sclk_level      = 1'b0;
        mosi_level      = 1'b0;
        cs_n_level      = 1'b1;
        rx_held         = '0;
        mismatches      = 0;
        burst_left      = 0;
        miso_style      = 2;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED_TICKS[r]) begin
            send_tick(DIRECTED_TICKS[r].cmd, DIRECTED_TICKS[r].cs_active,
                      DIRECTED_TICKS[r].tx_byte, DIRECTED_TICKS[r].miso,
                      DIRECTED_TICKS[r].typed, DIRECTED_TICKS[r].levels);
        end

        for (int p = 0; p < 10 + RANDOM_PHASES; p++) begin
            if (p < 10) begin
                mode_now = PHASE_MODE[p];
                half_now = PHASE_HALF[p];
            end else begin
                mode_now = 2'($urandom_range(0, 3));
                half_now = DIV_BITS'($urandom_range(1, 6));
            end
            // registers only change with the line quiet and nothing in flight
            settle_idle();
            write_register(smbs_pkg::CFG_SPI_MODE, {14'($urandom), mode_now});
            write_register(smbs_pkg::CFG_HALF_PERIOD, half_now);
            settings_used++;
            if (half_now == MAX_HALF) begin
                // longest half period: idle ticks and chip select only
                repeat (12) random_tick(1'b0);
            end else if (half_now > SLOW_HALF) begin
                // one long transfer to walk the counter far
                miso_style = 2;
                send_tick($urandom_range(0, 1) ? smbs_pkg::OP_WRITE : smbs_pkg::OP_READ,
                          1'b1, random_byte(), miso_for_tick(), 1'b0, '0);
            end else begin
                repeat (PHASE_TICKS) random_tick(1'b1);
            end
        end

        settle_idle();
        repeat (20) @(negedge i_clk);
        $display("%0d tick transactions, %0d writes and %0d reads started, %0d reads completed",
                 ticks_sent, writes_started, reads_started, reads_done);
        $display("%0d register settings across all four spi modes, half period 0 to 65535",
                 settings_used);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
